// ----- sv/rpsmd_pkg.sv -----
// Shared types, constants and helper functions for the radar pixel snap mosaic dither block.
// No dependencies; used by the top level and its checker.
package rpsmd_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int IDX_W     = $clog2(MAX_WIDTH);

  localparam int IN_W   = 56;
  localparam int OUT_W  = 56;
  localparam int CFG_W  = 7;
  localparam int CFG_AW = 2;

  localparam logic [CFG_AW-1:0] CFG_OPACITY = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_SCALE   = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_MOSAIC  = 2'd2;

  localparam logic [6:0] OPACITY_RST = 7'd50;
  localparam logic [6:0] OPACITY_MAX = 7'd100;
  localparam logic [2:0] SCALE_RST   = 3'd2;
  localparam logic [2:0] SCALE_MAX   = 3'd4;
  localparam logic [3:0] MOSAIC_RST  = 4'd2;
  localparam logic [3:0] MOSAIC_MAX  = 4'd8;
  localparam logic [7:0] ALPHA_RST   = 8'd127;

  // floor(a * ALPHA_RECIP / 2^ALPHA_SHIFT) == floor(a / 100) for a <= 25500
  localparam logic [14:0] ALPHA_RECIP = 15'd20972;
  localparam int          ALPHA_SHIFT = 21;

  // floor(v * HASH_RECIP / 2^HASH_SHIFT) == floor(v / 100) for v < 2^19
  localparam logic [19:0] HASH_RECIP = 20'd671089;
  localparam int          HASH_SHIFT = 26;
  localparam logic [6:0]  HASH_MOD   = 7'd100;
  localparam logic [6:0]  HASH_DOT   = 7'd35;
  // 3241 and 5479 reduced modulo 100
  localparam logic [6:0]  HASH_KX    = 7'd41;
  localparam logic [6:0]  HASH_KY    = 7'd79;

  localparam int MOSAIC_SHIFT = 16;

  typedef enum logic [1:0] {
    CLS_HIDDEN = 2'd0,
    CLS_RED    = 2'd1,
    CLS_YELLOW = 2'd2,
    CLS_GREEN  = 2'd3
  } cls_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  localparam rgb_t SNAP_RED    = '{red: 8'd194, green: 8'd41,  blue: 8'd30};
  localparam rgb_t SNAP_YELLOW = '{red: 8'd240, green: 8'd200, blue: 8'd0};
  localparam rgb_t SNAP_GREEN  = '{red: 8'd78,  green: 8'd148, blue: 8'd40};

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic cls_t classify(input rgb_t c, input logic [7:0] alpha);
    logic black;
    logic grey;
    black = (c.red < 8'd10) && (c.green < 8'd10) && (c.blue < 8'd10);
    grey  = (abs_diff(c.red, c.green) < 8'd20) && (abs_diff(c.green, c.blue) < 8'd20);
    if (black || grey || (alpha < 8'd10)) begin
      classify = CLS_HIDDEN;
    end else if ((c.red > 8'd100) && (c.green < 8'd80)) begin
      classify = CLS_RED;
    end else if ((c.red > 8'd80) && (c.green >= 8'd80)) begin
      classify = CLS_YELLOW;
    end else begin
      classify = CLS_GREEN;
    end
  endfunction

  function automatic rgb_t snap_color(input cls_t cls);
    unique case (cls)
      CLS_RED:    snap_color = SNAP_RED;
      CLS_YELLOW: snap_color = SNAP_YELLOW;
      CLS_GREEN:  snap_color = SNAP_GREEN;
      default:    snap_color = '0;
    endcase
  endfunction

  // ceil(2^16 / m) for m in 1..8
  function automatic logic [16:0] mosaic_recip(input logic [3:0] m);
    unique case (m)
      4'd1:    mosaic_recip = 17'd65536;
      4'd2:    mosaic_recip = 17'd32768;
      4'd3:    mosaic_recip = 17'd21846;
      4'd4:    mosaic_recip = 17'd16384;
      4'd5:    mosaic_recip = 17'd13108;
      4'd6:    mosaic_recip = 17'd10923;
      4'd7:    mosaic_recip = 17'd9363;
      default: mosaic_recip = 17'd8192;
    endcase
  endfunction

  // (41*dx + 79*dy) mod 100
  function automatic logic [6:0] hash_offset(input logic [1:0] dy, input logic [1:0] dx);
    unique case ({dy, dx})
      4'h0:    hash_offset = 7'd0;
      4'h1:    hash_offset = 7'd41;
      4'h2:    hash_offset = 7'd82;
      4'h3:    hash_offset = 7'd23;
      4'h4:    hash_offset = 7'd79;
      4'h5:    hash_offset = 7'd20;
      4'h6:    hash_offset = 7'd61;
      4'h7:    hash_offset = 7'd2;
      4'h8:    hash_offset = 7'd58;
      4'h9:    hash_offset = 7'd99;
      4'hA:    hash_offset = 7'd40;
      4'hB:    hash_offset = 7'd81;
      4'hC:    hash_offset = 7'd37;
      4'hD:    hash_offset = 7'd78;
      4'hE:    hash_offset = 7'd19;
      default: hash_offset = 7'd60;
    endcase
  endfunction

endpackage

// ----- sv/radar_pixel_snap_mosaic_dither.sv -----
// Radar pixel snap with mosaic class store, upscaling and hash dot dither.
// Depends on rpsmd_pkg.
//
// channel | dir | handshake          | payload
// in_     | in  | in_tvalid/tready   | in_tdata: src_x, src_y, blue, green, red, alpha
// out_    | out | out_tvalid/tready  | out_tdata: x, y, blue, green, red, alpha; out_tlast
// cfg_    | in  | cfg_wr_en          | cfg_index, cfg_wdata
//
// Each source pixel yields dot_scale^2 output beats (1 to 16), one per cycle from the
// output sequencer unless out_tready stalls; it takes the next pixel as the last beat
// of the current one is emitted. The class store is read once per pixel, written only
// by the top-left pixel of each mosaic cell, and needs no clearing after reset.
// rst_n is synchronous; a stalled out_tready holds the whole pipe back to in_tready.
module radar_pixel_snap_mosaic_dither (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // src_x[9:0], src_y[19:10], blue[27:20], green[35:28], red[43:36], alpha[51:44], zero pad
  input  logic [rpsmd_pkg::IN_W-1:0]      in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_x[11:0], out_y[23:12], blue[31:24], green[39:32], red[47:40], alpha[55:48]
  output logic [rpsmd_pkg::OUT_W-1:0]     out_tdata,
  output logic                            out_tlast,
  input  logic                            cfg_wr_en,
  input  logic [rpsmd_pkg::CFG_AW-1:0]    cfg_index,
  input  logic [rpsmd_pkg::CFG_W-1:0]     cfg_wdata
);

  // configuration
  logic [6:0]  op_r;
  logic [2:0]  scale_r;
  logic [3:0]  mosaic_r;
  logic [7:0]  alpha_r;
  logic [14:0] alpha_num;
  logic [29:0] alpha_prod;
  logic [16:0] recip;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r     <= rpsmd_pkg::OPACITY_RST;
      scale_r  <= rpsmd_pkg::SCALE_RST;
      mosaic_r <= rpsmd_pkg::MOSAIC_RST;
      alpha_r  <= rpsmd_pkg::ALPHA_RST;
    end else begin
      alpha_r <= alpha_prod[rpsmd_pkg::ALPHA_SHIFT +: 8];
      if (cfg_wr_en) begin
        unique case (cfg_index)
          rpsmd_pkg::CFG_OPACITY: begin
            op_r <= (cfg_wdata > rpsmd_pkg::OPACITY_MAX) ? rpsmd_pkg::OPACITY_MAX : cfg_wdata;
          end
          rpsmd_pkg::CFG_SCALE: begin
            if (cfg_wdata[2:0] == 3'd0) scale_r <= 3'd1;
            else if (cfg_wdata[2:0] > rpsmd_pkg::SCALE_MAX) scale_r <= rpsmd_pkg::SCALE_MAX;
            else scale_r <= cfg_wdata[2:0];
          end
          rpsmd_pkg::CFG_MOSAIC: begin
            if (cfg_wdata[3:0] == 4'd0) mosaic_r <= 4'd1;
            else if (cfg_wdata[3:0] > rpsmd_pkg::MOSAIC_MAX) mosaic_r <= rpsmd_pkg::MOSAIC_MAX;
            else mosaic_r <= cfg_wdata[3:0];
          end
          default: ;
        endcase
      end
    end
  end

  assign alpha_num  = {op_r, 8'd0} - 15'(op_r);
  assign alpha_prod = 30'(alpha_num) * 30'(rpsmd_pkg::ALPHA_RECIP);
  assign recip      = rpsmd_pkg::mosaic_recip(mosaic_r);

  // pipeline control
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic out_free, emit, last5;
  logic [1:0] dx_r, dy_r;
  logic [2:0] smax;

  assign smax     = scale_r - 3'd1;
  assign last5    = ({1'b0, dx_r} == smax) && ({1'b0, dy_r} == smax);
  assign out_free = !out_tvalid || out_tready;
  assign emit     = v5_r && out_free;
  assign rdy5     = !v5_r || (out_free && last5);
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_tready = rdy1;

  logic out_valid_r;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      dx_r        <= 2'd0;
      dy_r        <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) begin
        v5_r <= v4_r;
        dx_r <= 2'd0;
        dy_r <= 2'd0;
      end else if (emit) begin
        if ({1'b0, dx_r} == smax) begin
          dx_r <= 2'd0;
          dy_r <= dy_r + 2'd1;
        end else begin
          dx_r <= dx_r + 2'd1;
        end
      end
      if (emit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // stage 1: input register
  logic [9:0]              x1_r, y1_r;
  rpsmd_pkg::rgb_t         c1_r;
  logic [7:0]              a1_r;

  // stage 2: quotients, scaled base, new class
  logic [9:0]              x2_r, y2_r, qx2_r, qy2_r;
  logic [11:0]             bx2_r, by2_r;
  rpsmd_pkg::rgb_t         c2_r;
  rpsmd_pkg::cls_t         cn2_r;
  logic [26:0]             qx_prod, qy_prod;

  assign qx_prod = 27'(x1_r) * 27'(recip);
  assign qy_prod = 27'(y1_r) * 27'(recip);

  // stage 3: store access, hash sum
  logic [13:0]             ix_full, iy_full;
  logic                    tl2;
  logic [rpsmd_pkg::IDX_W-1:0] idx2;
  logic [18:0]             v2;
  logic                    tl3_r;
  rpsmd_pkg::cls_t         cn3_r, rd3_r;
  logic [11:0]             bx3_r, by3_r;
  rpsmd_pkg::rgb_t         c3_r;
  logic [18:0]             hv3_r;
  rpsmd_pkg::cls_t         class_mem [rpsmd_pkg::MAX_WIDTH];

  assign ix_full = 14'(qx2_r) * 14'(mosaic_r);
  assign iy_full = 14'(qy2_r) * 14'(mosaic_r);
  assign tl2     = (ix_full == 14'(x2_r)) && (iy_full == 14'(y2_r));
  assign idx2    = ix_full[rpsmd_pkg::IDX_W-1:0];
  assign v2      = 19'(bx2_r) * 19'(rpsmd_pkg::HASH_KX) + 19'(by2_r) * 19'(rpsmd_pkg::HASH_KY);

  always_ff @(posedge clk) begin
    if (v2_r && rdy3 && tl2) class_mem[idx2] <= cn2_r;
    if (rdy3) rd3_r <= class_mem[idx2];
  end

  // stage 4: hash quotient
  logic [38:0]             hq_prod;
  rpsmd_pkg::cls_t         cls4_r;
  logic [11:0]             bx4_r, by4_r;
  rpsmd_pkg::rgb_t         c4_r;
  logic [18:0]             hv4_r;
  logic [12:0]             hq4_r;

  assign hq_prod = 39'(hv3_r) * 39'(rpsmd_pkg::HASH_RECIP);

  // stage 5: output sequencer
  logic [18:0]             hrem;
  rpsmd_pkg::cls_t         cls5_r;
  logic [11:0]             bx5_r, by5_r;
  rpsmd_pkg::rgb_t         c5_r;
  logic [6:0]              h5_r;

  assign hrem = hv4_r - 19'(hq4_r) * 19'(rpsmd_pkg::HASH_MOD);

  always_ff @(posedge clk) begin
    if (rdy1) begin
      x1_r <= in_tdata[9:0];
      y1_r <= in_tdata[19:10];
      c1_r <= '{red: in_tdata[43:36], green: in_tdata[35:28], blue: in_tdata[27:20]};
      a1_r <= in_tdata[51:44];
    end
    if (rdy2) begin
      x2_r  <= x1_r;
      y2_r  <= y1_r;
      qx2_r <= qx_prod[rpsmd_pkg::MOSAIC_SHIFT +: 10];
      qy2_r <= qy_prod[rpsmd_pkg::MOSAIC_SHIFT +: 10];
      bx2_r <= 12'(x1_r) * 12'(scale_r);
      by2_r <= 12'(y1_r) * 12'(scale_r);
      c2_r  <= c1_r;
      cn2_r <= rpsmd_pkg::classify(c1_r, a1_r);
    end
    if (rdy3) begin
      tl3_r <= tl2;
      cn3_r <= cn2_r;
      bx3_r <= bx2_r;
      by3_r <= by2_r;
      c3_r  <= c2_r;
      hv3_r <= v2;
    end
    if (rdy4) begin
      cls4_r <= tl3_r ? cn3_r : rd3_r;
      bx4_r  <= bx3_r;
      by4_r  <= by3_r;
      c4_r   <= c3_r;
      hv4_r  <= hv3_r;
      hq4_r  <= hq_prod[rpsmd_pkg::HASH_SHIFT +: 13];
    end
    if (rdy5) begin
      cls5_r <= cls4_r;
      bx5_r  <= bx4_r;
      by5_r  <= by4_r;
      c5_r   <= c4_r;
      h5_r   <= hrem[6:0];
    end
  end

  // beat generation
  logic [7:0]      hsum, hmod;
  logic            show;
  logic [11:0]     ox, oy;
  rpsmd_pkg::rgb_t beat_color;
  logic [7:0]      beat_alpha;
  logic [rpsmd_pkg::OUT_W-1:0] out_data_r;
  logic            out_last_r;

  assign hsum = 8'(h5_r) + 8'(rpsmd_pkg::hash_offset(dy_r, dx_r));
  assign hmod = (hsum >= 8'(rpsmd_pkg::HASH_MOD)) ? (hsum - 8'(rpsmd_pkg::HASH_MOD)) : hsum;
  assign show = (cls5_r != rpsmd_pkg::CLS_HIDDEN) && (hmod < 8'(rpsmd_pkg::HASH_DOT));
  assign ox   = bx5_r + 12'(dx_r);
  assign oy   = by5_r + 12'(dy_r);
  assign beat_color = show ? rpsmd_pkg::snap_color(cls5_r) : c5_r;
  assign beat_alpha = show ? alpha_r : 8'd0;

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= {beat_alpha, beat_color, oy, ox};
      out_last_r <= last5;
    end
  end

  assign out_tdata = out_data_r;
  assign out_tlast = out_last_r;

endmodule

// ----- sv/rpsmd_checker.sv -----
// Port-level checker for radar_pixel_snap_mosaic_dither, bound to the top level.
// Depends on rpsmd_pkg.
module rpsmd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [rpsmd_pkg::OUT_W-1:0] out_tdata,
  input logic                        out_tlast
);

  // hold a stalled beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output beat changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // a visible dot carries a snapped color
  a_dot_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[55:48] != 8'd0) |->
      (out_tdata[47:24] == rpsmd_pkg::SNAP_RED) ||
      (out_tdata[47:24] == rpsmd_pkg::SNAP_YELLOW) ||
      (out_tdata[47:24] == rpsmd_pkg::SNAP_GREEN))
    else $error("shown dot with unsnapped color");

  // advance a square without gaps, row by row
  a_square_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid &&
      ((out_tdata[23:12] == $past(out_tdata[23:12])) ||
       (out_tdata[23:12] == $past(out_tdata[23:12]) + 12'd1)))
    else $error("square beats broken");

endmodule

bind radar_pixel_snap_mosaic_dither rpsmd_checker u_rpsmd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
